FILE: rtl/quorum_commit_index_assert.svh
// Assertion macros for the quorum commit index block.
`ifndef QUORUM_COMMIT_INDEX_ASSERT_SVH
`define QUORUM_COMMIT_INDEX_ASSERT_SVH
`ifndef SYNTHESIS
`define QCI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("quorum commit index check failed");
`define QCI_ASSERT_NEXT(label, clk, rst_n, cond, result) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error("quorum commit index sequence check failed");
`else
`define QCI_ASSERT(label, clk, rst_n, prop)
`define QCI_ASSERT_NEXT(label, clk, rst_n, cond, result)
`endif
`endif

FILE: rtl/qci_pkg.sv
// Shared constants, codes and control types of the quorum commit index block.
`default_nettype none
package qci_pkg;

    localparam int MAX_PARTICIPANTS_DEF = 16;
    localparam int INDEX_BITS_DEF = 32;

    // Width used for comparisons between counts, ranks and the write concern.
    localparam int CMP_W = 8;

    localparam int FL_ALLOWED = 0;
    localparam int FL_SNAP = 1;
    localparam int FL_FORCED = 2;

    localparam logic [2:0] FAIL_NONE = 3'd0;
    localparam logic [2:0] FAIL_FEW_PARTS = 3'd1;
    localparam logic [2:0] FAIL_FORCED = 3'd2;
    localparam logic [2:0] FAIL_SHORT = 3'd3;
    localparam logic [2:0] FAIL_NON_ELIG = 3'd4;

    localparam logic [2:0] EX_NONE = 3'd0;
    localparam logic [2:0] EX_NOT_ALLOWED = 3'd1;
    localparam logic [2:0] EX_WRONG_TERM = 3'd2;
    localparam logic [2:0] EX_NO_SNAP = 3'd3;
    localparam logic [2:0] EX_BEHIND = 3'd4;

    typedef struct packed {
        logic wr;
        logic init;
        logic rank;
        logic shift;
    } qci_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/quorum_commit_index.sv
// Top level of the quorum commit index block: ring of participant cells and run control.
//
//   Channel   Direction   Handshake                 Carries
//   cfg       in          cfg_we                    write concern (cfg_wdata)
//   in        in          in_valid / in_ready       one participant per request
//   out       out         out_valid / out_ready     one result row per participant
//
// Participant requests are taken while loading. The request flagged as the last
// participant starts a run on the cell ring (one full rotation to build ranks, one
// to gather minima and quorum values), then a decision, then one row per stored
// participant, each loaded into the output register when it is empty or being read.
// Requests are refused from the final request until the last row has been loaded
// into the output register. A stalled output only stops the ring. Reset sets the
// write concern to 1 and empties the store.
`default_nettype none
module quorum_commit_index
    import qci_pkg::*;
#(
    parameter int MAX_PARTICIPANTS = MAX_PARTICIPANTS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [4:0]            cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            participant_id,
    input  wire logic [31:0]           acked_term,
    input  wire logic [INDEX_BITS-1:0] acked_index,
    input  wire logic [INDEX_BITS-1:0] synced_index,
    input  wire logic                  quorum_allowed,
    input  wire logic                  snapshot_ok,
    input  wire logic                  forced_member,
    input  wire logic                  last_participant,
    input  wire logic [31:0]           leader_term,
    input  wire logic [INDEX_BITS-1:0] spearhead_index,
    input  wire logic [INDEX_BITS-1:0] prior_commit,
    input  wire logic [INDEX_BITS-1:0] prior_sync_commit,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [INDEX_BITS-1:0]      commit_index,
    output logic [INDEX_BITS-1:0]      sync_commit_index,
    output logic [2:0]                 fail_code,
    output logic [7:0]                 culprit_id,
    output logic [7:0]                 report_id,
    output logic                       in_quorum,
    output logic [2:0]                 exclusion_code,
    output logic                       final_row
);

    `include "quorum_commit_index_assert.svh"

    localparam int MAXP = MAX_PARTICIPANTS;
    localparam int IB = INDEX_BITS;
    localparam int PW = (MAXP > 1) ? $clog2(MAXP) : 1;
    localparam int RW = $clog2(MAXP + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANK,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [RW-1:0] count_reg, count_next;
    logic [RW-1:0] n_reg, n_next;
    logic [RW-1:0] step_reg, step_next;
    logic [4:0]    wc_reg, wc_next;
    logic          out_valid_reg, out_valid_next;

    // Run payload: leader values, gathered minima and quorum values, decision.
    logic [31:0]   lterm_reg, lterm_next;
    logic [IB-1:0] spear_reg, spear_next;
    logic [IB-1:0] pc_reg, pc_next;
    logic [IB-1:0] ps_reg, ps_next;
    logic [RW-1:0] elig_reg, elig_next;
    logic          stop_reg, stop_next;
    logic          f2_reg, f2_next;
    logic [7:0]    cul_reg, cul_next;
    logic [IB-1:0] min_fc_reg, min_fc_next;
    logic [IB-1:0] min_fs_reg, min_fs_next;
    logic [7:0]    fid_reg, fid_next;
    logic [IB-1:0] qa_reg, qa_next;
    logic [IB-1:0] qs_reg, qs_next;
    logic [IB-1:0] commit_reg, commit_next;
    logic [IB-1:0] sync_reg, sync_next;
    logic [2:0]    fail_reg, fail_next;
    logic [7:0]    culprit_reg, culprit_next;
    logic          hasq_reg, hasq_next;
    logic          ex3_reg, ex3_next;
    logic          ex4_reg, ex4_next;

    // Output register.
    logic [IB-1:0] o_commit_reg, o_commit_next;
    logic [IB-1:0] o_sync_reg, o_sync_next;
    logic [2:0]    o_fail_reg, o_fail_next;
    logic [7:0]    o_cul_reg, o_cul_next;
    logic [7:0]    o_id_reg, o_id_next;
    logic          o_inq_reg, o_inq_next;
    logic [2:0]    o_ex_reg, o_ex_next;
    logic          o_final_reg, o_final_next;

    qci_ctl_t      ctl;
    logic          acc_in;
    logic          acc_out;
    logic          room;
    logic [RW-1:0] count_full;
    logic [RW-1:0] cell_n;

    // Token ring signals, indexed by cell position.
    logic [7:0]    t_id [MAXP];
    logic [31:0]   t_term [MAXP];
    logic [IB-1:0] t_idx [MAXP];
    logic [IB-1:0] t_sync [MAXP];
    logic [2:0]    t_flags [MAXP];
    logic [PW-1:0] t_pos [MAXP];
    logic          t_valid [MAXP];
    logic [RW-1:0] t_ri [MAXP];
    logic [RW-1:0] t_rs [MAXP];

    logic          h_elig;
    logic [CMP_W-1:0] wc8, n8, e8;
    logic [IB-1:0] cm, sm;
    logic [2:0]    row_ex;

    assign acc_in = in_valid && in_ready;
    assign acc_out = out_valid_reg && out_ready;
    assign room = count_reg < RW'(MAXP);
    assign count_full = count_reg + RW'(room);
    // The cells see the size of the run being started while loading.
    assign cell_n = (state_reg == ST_LOAD) ? count_full : n_reg;

    genvar k;
    generate
        for (k = 0; k < MAXP; k++)
        begin : g_cell
            qci_cell #(
                .MAXP (MAXP),
                .IB   (IB),
                .K    (k)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .wr_addr    (count_reg[PW-1:0]),
                .run_n      (cell_n),
                .lterm      ((state_reg == ST_LOAD) ? leader_term : lterm_reg),
                .w_id       (participant_id),
                .w_term     (acked_term),
                .w_idx      (acked_index),
                .w_sync     (synced_index),
                .w_flags    ({forced_member, snapshot_ok, quorum_allowed}),
                .tin_id     (t_id[(k + 1) % MAXP]),
                .tin_term   (t_term[(k + 1) % MAXP]),
                .tin_idx    (t_idx[(k + 1) % MAXP]),
                .tin_sync   (t_sync[(k + 1) % MAXP]),
                .tin_flags  (t_flags[(k + 1) % MAXP]),
                .tin_pos    (t_pos[(k + 1) % MAXP]),
                .tin_valid  (t_valid[(k + 1) % MAXP]),
                .tin_ri     (t_ri[(k + 1) % MAXP]),
                .tin_rs     (t_rs[(k + 1) % MAXP]),
                .tout_id    (t_id[k]),
                .tout_term  (t_term[k]),
                .tout_idx   (t_idx[k]),
                .tout_sync  (t_sync[k]),
                .tout_flags (t_flags[k]),
                .tout_pos   (t_pos[k]),
                .tout_valid (t_valid[k]),
                .tout_ri    (t_ri[k]),
                .tout_rs    (t_rs[k])
            );
        end
    endgenerate

    // The head cell holds the token of the participant being scanned or reported.
    assign h_elig = t_valid[0] && t_flags[0][FL_ALLOWED] && t_flags[0][FL_SNAP]
                    && (t_term[0] == lterm_reg);
    assign wc8 = CMP_W'(wc_reg);
    assign n8 = CMP_W'(n_reg);
    assign e8 = CMP_W'(elig_reg);
    assign cm = (min_fc_reg < qa_reg) ? min_fc_reg : qa_reg;
    assign sm = (min_fs_reg < qs_reg) ? min_fs_reg : qs_reg;

    // Exclusion code of the head participant for the failing outcomes.
    always_comb
    begin
        row_ex = EX_NONE;
        if (ex3_reg)
        begin
            if (!t_flags[0][FL_ALLOWED])
                row_ex = EX_NOT_ALLOWED;
            else if (!t_flags[0][FL_SNAP])
                row_ex = EX_NO_SNAP;
            else if ((t_term[0] < lterm_reg) ||
                     ((t_term[0] == lterm_reg) && (t_idx[0] < spear_reg)))
                row_ex = EX_BEHIND;
        end
        else if (ex4_reg)
        begin
            if (!t_flags[0][FL_ALLOWED])
                row_ex = EX_NOT_ALLOWED;
            else if (t_term[0] != lterm_reg)
                row_ex = EX_WRONG_TERM;
            else if (!t_flags[0][FL_SNAP])
                row_ex = EX_NO_SNAP;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next = n_reg;
        step_next = step_reg;
        wc_next = cfg_we ? cfg_wdata : wc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        lterm_next = lterm_reg;
        spear_next = spear_reg;
        pc_next = pc_reg;
        ps_next = ps_reg;
        elig_next = elig_reg;
        stop_next = stop_reg;
        f2_next = f2_reg;
        cul_next = cul_reg;
        min_fc_next = min_fc_reg;
        min_fs_next = min_fs_reg;
        fid_next = fid_reg;
        qa_next = qa_reg;
        qs_next = qs_reg;
        commit_next = commit_reg;
        sync_next = sync_reg;
        fail_next = fail_reg;
        culprit_next = culprit_reg;
        hasq_next = hasq_reg;
        ex3_next = ex3_reg;
        ex4_next = ex4_reg;
        o_commit_next = o_commit_reg;
        o_sync_next = o_sync_reg;
        o_fail_next = o_fail_reg;
        o_cul_next = o_cul_reg;
        o_id_next = o_id_reg;
        o_inq_next = o_inq_reg;
        o_ex_next = o_ex_reg;
        o_final_next = o_final_reg;
        ctl = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (acc_in)
                begin
                    // A full store drops the participant but still honors a final flag.
                    ctl.wr = room;
                    count_next = count_full;
                    if (last_participant)
                    begin
                        ctl.init = 1'b1;
                        count_next = '0;
                        n_next = count_full;
                        lterm_next = leader_term;
                        spear_next = spearhead_index;
                        pc_next = prior_commit;
                        ps_next = prior_sync_commit;
                        min_fc_next = spearhead_index;
                        min_fs_next = spearhead_index;
                        fid_next = '0;
                        elig_next = '0;
                        stop_next = 1'b0;
                        f2_next = 1'b0;
                        cul_next = '0;
                        qa_next = '0;
                        qs_next = '0;
                        step_next = '0;
                        state_next = ST_RANK;
                    end
                end
            end
            ST_RANK:
            begin
                ctl.rank = 1'b1;
                ctl.shift = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == RW'(MAXP - 1))
                begin
                    step_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.shift = 1'b1;
                step_next = step_reg + 1'b1;
                elig_next = elig_reg + RW'(h_elig);
                // Forced members in load order; the first one in a wrong term ends it.
                if (t_valid[0] && t_flags[0][FL_FORCED] && !stop_reg)
                begin
                    if (t_term[0] != lterm_reg)
                    begin
                        f2_next = 1'b1;
                        cul_next = t_id[0];
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        if (t_idx[0] < min_fc_reg)
                        begin
                            min_fc_next = t_idx[0];
                            fid_next = t_id[0];
                        end
                        if (t_sync[0] < min_fs_reg)
                            min_fs_next = t_sync[0];
                    end
                end
                if (h_elig && (CMP_W'(t_ri[0]) + 1'b1 == wc8))
                    qa_next = t_idx[0];
                if (h_elig && (CMP_W'(t_rs[0]) + 1'b1 == wc8))
                    qs_next = t_sync[0];
                if (step_reg == RW'(MAXP - 1))
                begin
                    step_next = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                commit_next = pc_reg;
                sync_next = ps_reg;
                fail_next = FAIL_NONE;
                culprit_next = '0;
                hasq_next = 1'b0;
                ex3_next = 1'b0;
                ex4_next = 1'b0;
                if ((wc8 > n8) && (n8 == e8))
                    fail_next = FAIL_FEW_PARTS;
                else if (f2_reg)
                begin
                    fail_next = FAIL_FORCED;
                    culprit_next = cul_reg;
                end
                else if (wc_reg == '0)
                begin
                    commit_next = min_fc_reg;
                    sync_next = min_fs_reg;
                end
                else if (wc8 <= e8)
                begin
                    commit_next = cm;
                    sync_next = sm;
                    if (spear_reg == cm)
                        hasq_next = 1'b1;
                    else if (min_fc_reg < qa_reg)
                    begin
                        fail_next = FAIL_FORCED;
                        culprit_next = fid_reg;
                    end
                    else
                    begin
                        fail_next = FAIL_SHORT;
                        hasq_next = 1'b1;
                        ex3_next = 1'b1;
                    end
                end
                else
                begin
                    fail_next = FAIL_NON_ELIG;
                    ex4_next = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (step_reg >= n_reg)
                    state_next = ST_LOAD;
                else if (!out_valid_reg || out_ready)
                begin
                    ctl.shift = 1'b1;
                    step_next = step_reg + 1'b1;
                    out_valid_next = 1'b1;
                    o_commit_next = commit_reg;
                    o_sync_next = sync_reg;
                    o_fail_next = fail_reg;
                    o_cul_next = culprit_reg;
                    o_id_next = t_id[0];
                    o_inq_next = hasq_reg && h_elig && (CMP_W'(t_ri[0]) < wc8);
                    o_ex_next = row_ex;
                    o_final_next = (step_reg + 1'b1) == n_reg;
                    if ((step_reg + 1'b1) == n_reg)
                        state_next = ST_LOAD;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            n_reg <= '0;
            step_reg <= '0;
            wc_reg <= 5'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg <= n_next;
            step_reg <= step_next;
            wc_reg <= wc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lterm_reg <= lterm_next;
        spear_reg <= spear_next;
        pc_reg <= pc_next;
        ps_reg <= ps_next;
        elig_reg <= elig_next;
        stop_reg <= stop_next;
        f2_reg <= f2_next;
        cul_reg <= cul_next;
        min_fc_reg <= min_fc_next;
        min_fs_reg <= min_fs_next;
        fid_reg <= fid_next;
        qa_reg <= qa_next;
        qs_reg <= qs_next;
        commit_reg <= commit_next;
        sync_reg <= sync_next;
        fail_reg <= fail_next;
        culprit_reg <= culprit_next;
        hasq_reg <= hasq_next;
        ex3_reg <= ex3_next;
        ex4_reg <= ex4_next;
        o_commit_reg <= o_commit_next;
        o_sync_reg <= o_sync_next;
        o_fail_reg <= o_fail_next;
        o_cul_reg <= o_cul_next;
        o_id_reg <= o_id_next;
        o_inq_reg <= o_inq_next;
        o_ex_reg <= o_ex_next;
        o_final_reg <= o_final_next;
    end

    assign in_ready = (state_reg == ST_LOAD);
    assign out_valid = out_valid_reg;
    assign commit_index = o_commit_reg;
    assign sync_commit_index = o_sync_reg;
    assign fail_code = o_fail_reg;
    assign culprit_id = o_cul_reg;
    assign report_id = o_id_reg;
    assign in_quorum = o_inq_reg;
    assign exclusion_code = o_ex_reg;
    assign final_row = o_final_reg;

    // The fill count never passes the store size.
    `QCI_ASSERT(a_count_bound, clk, rst_n, count_reg <= RW'(MAXP))
    // Rows are only loaded while reporting a run.
    `QCI_ASSERT_NEXT(a_row_source, clk, rst_n, !out_valid_reg && state_reg != ST_EMIT, !out_valid_reg)
    // After the final row is loaded the block is ready for the next run.
    `QCI_ASSERT_NEXT(a_final_then_load, clk, rst_n, state_reg == ST_EMIT && ctl.shift && o_final_next, in_ready)
    // A quorum membership is reported only for outcomes that form a quorum.
    `QCI_ASSERT(a_inq_fail, clk, rst_n, (out_valid_reg && in_quorum) |-> (fail_code == FAIL_NONE || fail_code == FAIL_SHORT))

endmodule
`default_nettype wire

FILE: rtl/qci_cell.sv
// One cell of the participant ring: a stored participant and a circulating token.
`default_nettype none
module qci_cell
    import qci_pkg::*;
#(
    parameter int MAXP = MAX_PARTICIPANTS_DEF,
    parameter int IB = INDEX_BITS_DEF,
    parameter int K = 0
) (
    input  wire logic                                 clk,
    input  wire qci_ctl_t                             ctl,
    input  wire logic [((MAXP > 1) ? $clog2(MAXP) : 1)-1:0] wr_addr,
    input  wire logic [$clog2(MAXP + 1)-1:0]          run_n,
    input  wire logic [31:0]                          lterm,
    input  wire logic [7:0]                           w_id,
    input  wire logic [31:0]                          w_term,
    input  wire logic [IB-1:0]                        w_idx,
    input  wire logic [IB-1:0]                        w_sync,
    input  wire logic [2:0]                           w_flags,
    input  wire logic [7:0]                           tin_id,
    input  wire logic [31:0]                          tin_term,
    input  wire logic [IB-1:0]                        tin_idx,
    input  wire logic [IB-1:0]                        tin_sync,
    input  wire logic [2:0]                           tin_flags,
    input  wire logic [((MAXP > 1) ? $clog2(MAXP) : 1)-1:0] tin_pos,
    input  wire logic                                 tin_valid,
    input  wire logic [$clog2(MAXP + 1)-1:0]          tin_ri,
    input  wire logic [$clog2(MAXP + 1)-1:0]          tin_rs,
    output logic [7:0]                                tout_id,
    output logic [31:0]                               tout_term,
    output logic [IB-1:0]                             tout_idx,
    output logic [IB-1:0]                             tout_sync,
    output logic [2:0]                                tout_flags,
    output logic [((MAXP > 1) ? $clog2(MAXP) : 1)-1:0] tout_pos,
    output logic                                      tout_valid,
    output logic [$clog2(MAXP + 1)-1:0]               tout_ri,
    output logic [$clog2(MAXP + 1)-1:0]               tout_rs
);

    localparam int PW = (MAXP > 1) ? $clog2(MAXP) : 1;
    localparam int RW = $clog2(MAXP + 1);

    logic [7:0]    s_id_reg;
    logic [31:0]   s_term_reg;
    logic [IB-1:0] s_idx_reg;
    logic [IB-1:0] s_sync_reg;
    logic [2:0]    s_flags_reg;

    logic [7:0]    t_id_reg;
    logic [31:0]   t_term_reg;
    logic [IB-1:0] t_idx_reg;
    logic [IB-1:0] t_sync_reg;
    logic [2:0]    t_flags_reg;
    logic [PW-1:0] t_pos_reg;
    logic          t_valid_reg;
    logic [RW-1:0] t_ri_reg;
    logic [RW-1:0] t_rs_reg;

    logic          wr_hit;
    logic          s_valid;
    logic          s_elig;
    logic          inc_ri;
    logic          inc_rs;

    assign wr_hit = ctl.wr && (wr_addr == PW'(K));
    assign s_valid = RW'(K) < run_n;
    assign s_elig = s_valid && s_flags_reg[FL_ALLOWED] && s_flags_reg[FL_SNAP]
                    && (s_term_reg == lterm);

    // The stored participant outranks the visiting token when its key is larger,
    // or equal with an earlier load position.
    assign inc_ri = ctl.rank && s_elig && ((s_idx_reg > t_idx_reg) ||
                    ((s_idx_reg == t_idx_reg) && (PW'(K) < t_pos_reg)));
    assign inc_rs = ctl.rank && s_elig && ((s_sync_reg > t_sync_reg) ||
                    ((s_sync_reg == t_sync_reg) && (PW'(K) < t_pos_reg)));

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            s_id_reg <= w_id;
            s_term_reg <= w_term;
            s_idx_reg <= w_idx;
            s_sync_reg <= w_sync;
            s_flags_reg <= w_flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            t_id_reg <= wr_hit ? w_id : s_id_reg;
            t_term_reg <= wr_hit ? w_term : s_term_reg;
            t_idx_reg <= wr_hit ? w_idx : s_idx_reg;
            t_sync_reg <= wr_hit ? w_sync : s_sync_reg;
            t_flags_reg <= wr_hit ? w_flags : s_flags_reg;
            t_pos_reg <= PW'(K);
            t_valid_reg <= s_valid;
            t_ri_reg <= '0;
            t_rs_reg <= '0;
        end
        else if (ctl.shift)
        begin
            t_id_reg <= tin_id;
            t_term_reg <= tin_term;
            t_idx_reg <= tin_idx;
            t_sync_reg <= tin_sync;
            t_flags_reg <= tin_flags;
            t_pos_reg <= tin_pos;
            t_valid_reg <= tin_valid;
            t_ri_reg <= tin_ri;
            t_rs_reg <= tin_rs;
        end
    end

    assign tout_id = t_id_reg;
    assign tout_term = t_term_reg;
    assign tout_idx = t_idx_reg;
    assign tout_sync = t_sync_reg;
    assign tout_flags = t_flags_reg;
    assign tout_pos = t_pos_reg;
    assign tout_valid = t_valid_reg;
    assign tout_ri = t_ri_reg + RW'(inc_ri);
    assign tout_rs = t_rs_reg + RW'(inc_rs);

endmodule
`default_nettype wire
